// ===== rtl/core/bpc_pkg.sv =====
// Shared types, constants and codes for the breakpoint pass count unit.
package bpc_pkg;

  localparam int NUM_ENTRIES_DEF = 8;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int ADDR_W          = 16;
  localparam int LIMIT_W         = 16;
  localparam int IDXF_W          = 3;

  typedef enum logic {
    CMD_CHECK   = 1'b0,
    CMD_PROGRAM = 1'b1
  } command_t;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] pc_address;
    logic [IDXF_W-1:0] entry_index;
    logic [ADDR_W-1:0] entry_address;
    logic [LIMIT_W-1:0] entry_limit;
    logic              entry_set;
    logic              entry_enabled;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [IDXF_W-1:0] hit_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;  // transaction accepted this cycle
    logic prog_wr;    // program transaction: write entry now
    logic eval;       // evaluate current scan entry
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic prog_req;   // incoming transaction is a program command
    logic bp_on;      // global enable
    logic hit;        // current entry hits
    logic last;       // current entry is the last one
  } ctl_status_t;

endpackage

// ===== rtl/core/bpc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module bpc_ram import bpc_pkg::*; #(
  parameter int WIDTH = ADDR_W,
  parameter int DEPTH = NUM_ENTRIES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bpc_datapath.sv =====
// Breakpoint table storage, scan compare and saturating pass counters.
module bpc_datapath import bpc_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  ctl_cmd_t    cmd,
  output ctl_status_t stat,
  output out_item_t   out_data
);

  localparam int IDX_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int ENTRY_W = ADDR_W + LIMIT_W + COUNT_BITS + 2;
  localparam int CMP_W   = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic                   bp_on_r;
  logic [ADDR_W-1:0]      pc_r;
  logic [IDX_W-1:0]       ek_r;
  logic [NUM_ENTRIES-1:0] valid_r;
  logic                   res_hit_r;
  logic [IDXF_W-1:0]      res_idx_r;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [ENTRY_W-1:0]     entry;

  logic [ADDR_W-1:0]      e_addr;
  logic [LIMIT_W-1:0]     e_limit;
  logic [COUNT_BITS-1:0]  e_run;
  logic                   e_set;
  logic                   e_en;
  logic [COUNT_BITS-1:0]  run_inc;
  logic [COUNT_BITS-1:0]  run_wb;
  logic                   match;
  logic                   hit_now;
  logic                   last;
  logic                   idx_ok;

  bpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entries never programmed read as all zero
  assign entry   = valid_r[ek_r] ? ram_rdata : '0;
  assign e_addr  = entry[ENTRY_W-1 -: ADDR_W];
  assign e_limit = entry[COUNT_BITS+2 +: LIMIT_W];
  assign e_run   = entry[2 +: COUNT_BITS];
  assign e_set   = entry[1];
  assign e_en    = entry[0];

  assign run_inc = (e_run == '1) ? e_run : e_run + COUNT_BITS'(1);
  assign run_wb  = hit_now ? COUNT_BITS'(0) : run_inc;
  assign match   = e_set && e_en && (e_addr == pc_r);
  assign hit_now = match && (CMP_W'(run_inc) >= CMP_W'(e_limit));
  assign last    = (ek_r == IDX_W'(NUM_ENTRIES - 1));
  assign idx_ok  = (32'(in_data.entry_index) < NUM_ENTRIES);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ek_r;
    ram_wdata = {e_addr, e_limit, run_wb, e_set, e_en};
    if (cmd.prog_wr) begin
      ram_we    = idx_ok;
      ram_waddr = IDX_W'(in_data.entry_index);
      ram_wdata = {in_data.entry_address, in_data.entry_limit, COUNT_BITS'(0),
                   in_data.entry_set, in_data.entry_enabled};
    end else if (cmd.eval && match) begin
      ram_we = 1'b1;
    end
  end

  // prefetch the next entry while the current one is evaluated
  assign ram_raddr = (cmd.eval && !last) ? ek_r + IDX_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_on_r   <= 1'b0;
      valid_r   <= '0;
      res_hit_r <= 1'b0;
      res_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        bp_on_r <= cfg_wdata;
      end
      if (cmd.prog_wr && idx_ok) begin
        valid_r[IDX_W'(in_data.entry_index)] <= 1'b1;
      end
      if (cmd.load_item) begin
        res_hit_r <= 1'b0;
        res_idx_r <= '0;
      end else if (cmd.eval && hit_now) begin
        res_hit_r <= 1'b1;
        res_idx_r <= IDXF_W'(ek_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pc_r <= in_data.pc_address;
      ek_r <= '0;
    end else if (cmd.eval) begin
      ek_r <= ek_r + IDX_W'(1);
    end
  end

  assign stat.prog_req = (in_data.command == CMD_PROGRAM);
  assign stat.bp_on    = bp_on_r;
  assign stat.hit      = hit_now;
  assign stat.last     = last;

  assign out_data.hit       = res_hit_r;
  assign out_data.hit_index = res_idx_r;

  a_hit_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && hit_now) |=> res_hit_r)
    else $error("hit found in scan not captured");

  a_nohit_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !res_hit_r |-> (res_idx_r == '0))
    else $error("hit index nonzero without hit");

endmodule

// ===== rtl/core/bpc_controller.sv =====
// Sequencing state machine: accept, scan entries, present result.
module bpc_controller import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  output logic        out_valid,
  input  ctl_status_t stat,
  output ctl_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (stat.prog_req || !stat.bp_on) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.hit || stat.last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.load_item = accept;
        cmd.prog_wr   = accept && stat.prog_req;
      end
      ST_SCAN: begin
        cmd.eval = 1'b1;
      end
      ST_RESULT: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transaction accepted but block not busy next cycle");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> !(cmd.prog_wr || cmd.load_item))
    else $error("program write during scan");

endmodule

// ===== rtl/core/breakpoint_pass_count_unit.sv =====
// Top level of the breakpoint pass count unit.
//
// Debug breakpoint table with pass counts. A transaction is accepted at a
// clock edge where start is high and busy is low; in_data carries it.
// A program command writes one table entry and clears its running count.
// A check command compares pc_address against the entries in index order,
// one entry per cycle (the table RAM's single read port sets this pace).
// Every transaction produces exactly one result on out_data, flagged by a
// one-cycle out_valid strobe; the receiver cannot stall it.
// The strobe comes in the cycle after the accept edge for a program command
// or while the global enable is off; for a check it comes after k entries
// (1..NUM_ENTRIES) are scanned, up to the hit or the last entry. busy drops
// the cycle after the strobe; no new transaction is accepted before then.
// cfg_we/cfg_wdata write the global enable at any edge; write only while
// idle. Synchronous reset (rst_n low) clears the enable and all entries;
// entries are tracked by valid flags, so no clearing pass is needed.
module breakpoint_pass_count_unit import bpc_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  ctl_cmd_t    cmd;
  ctl_status_t stat;

  bpc_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpc_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
